>>> hdl/rsp_pkg.sv
// Shared types and constants for the radix select push counter.
package rsp_pkg;

    // Count width and modulus; the modulus is a multiple of 10^4 and 8^4
    localparam int COUNT_W = 22;
    localparam logic [COUNT_W-1:0] COUNT_MODULUS = 22'd2560000;

    // Key codes that clear the count
    localparam logic [7:0] KEY_CLEAR_A = 8'd115;
    localparam logic [7:0] KEY_CLEAR_B = 8'd114;

    // Switch codes
    localparam logic [7:0] SW_NEXT_RADIX = 8'd1;
    localparam logic [7:0] SW_ADD_SQUARE = 8'd2;
    localparam logic [7:0] SW_ADD_RADIX  = 8'd3;
    localparam logic [7:0] SW_ADD_ONE    = 8'd4;

    // Radix codes
    localparam logic [1:0] RADIX_DEC = 2'd0;
    localparam logic [1:0] RADIX_OCT = 2'd1;
    localparam logic [1:0] RADIX_QUA = 2'd2;
    localparam logic [1:0] RADIX_BIN = 2'd3;

    // Divide by ten through a reciprocal: q = (v * DIV10_MULT) >> DIV10_SHIFT,
    // exact for every 22-bit v
    localparam int DIV10_SHIFT = 26;
    localparam logic [22:0] DIV10_MULT = 23'd6710887;

    // Maximum number of digits on the result
    localparam int SHOWN_MAX = 4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_CONVERT,
        ST_EMIT
    } rsp_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;   // latch the input transfer
        logic update;    // apply clear and switch, seed the conversion
        logic step;      // produce one digit
        logic emit;      // load the output register
    } rsp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic last_digit;
    } rsp_status_t;

    // Base of a radix code
    function automatic logic [3:0] radix_base(input logic [1:0] code);
        logic [3:0] b;
        case (code)
            RADIX_DEC: b = 4'd10;
            RADIX_OCT: b = 4'd8;
            RADIX_QUA: b = 4'd4;
            RADIX_BIN: b = 4'd2;
            default:   b = 4'd10;
        endcase
        return b;
    endfunction

    // Square of the base of a radix code
    function automatic logic [6:0] radix_square(input logic [1:0] code);
        logic [6:0] s;
        case (code)
            RADIX_DEC: s = 7'd100;
            RADIX_OCT: s = 7'd64;
            RADIX_QUA: s = 7'd16;
            RADIX_BIN: s = 7'd4;
            default:   s = 7'd100;
        endcase
        return s;
    endfunction

endpackage

>>> hdl/rsp_ctrl.sv
// Controller state machine for the radix select push counter.
module rsp_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  rsp_pkg::rsp_status_t status,
    output rsp_pkg::rsp_cmd_t   cmd
);
    import rsp_pkg::*;

    rsp_state_t state_reg;
    rsp_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    // State and output-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_CONVERT;
            end
            ST_CONVERT:
            begin
                cmd.step = 1'b1;
                if (status.last_digit)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // wait until the output register is free or being drained
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> hdl/rsp_datapath.sv
// Datapath: count and radix state, digit conversion and output register.
module rsp_datapath #(
    parameter int DIGITS = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           key_code,
    input  logic [7:0]           switch_code,
    input  rsp_pkg::rsp_cmd_t    cmd,
    output rsp_pkg::rsp_status_t status,
    output logic [3:0]           digit_thousands,
    output logic [3:0]           digit_hundreds,
    output logic [3:0]           digit_tens,
    output logic [3:0]           digit_units,
    output logic [1:0]           radix_code
);
    import rsp_pkg::*;

    localparam int SHOWN = (DIGITS < SHOWN_MAX) ? DIGITS : SHOWN_MAX;
    localparam int IDX_W = (SHOWN > 1) ? $clog2(SHOWN) : 1;

    // Captured input
    logic [7:0]         key_reg;
    logic [7:0]         switch_reg;

    // Block state
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [1:0]         radix_reg;
    logic [1:0]         radix_next;

    // Conversion
    logic [COUNT_W-1:0] work_reg;
    logic [COUNT_W-1:0] work_next;
    logic [IDX_W-1:0]   idx_reg;
    logic [3:0]         dig_reg [SHOWN_MAX];

    // Output register
    logic [3:0]         thousands_reg;
    logic [3:0]         hundreds_reg;
    logic [3:0]         tens_reg;
    logic [3:0]         units_reg;
    logic [1:0]         radix_out_reg;

    logic               key_clear;
    logic [COUNT_W-1:0] start_count;
    logic [6:0]         inc;
    logic [COUNT_W-1:0] sum;
    logic [COUNT_W-1:0] count_upd;
    logic [44:0]        prod;
    logic [COUNT_W-1:0] quot;
    logic [COUNT_W-1:0] quot_times_base;
    logic [COUNT_W-1:0] rem_full;
    logic [3:0]         rem;

    // Clear, then switch action, then wrap modulo the count modulus
    always_comb
    begin
        key_clear   = (key_reg == KEY_CLEAR_A) || (key_reg == KEY_CLEAR_B);
        start_count = key_clear ? '0 : count_reg;
        radix_next  = radix_reg;
        inc         = '0;
        case (switch_reg)
            SW_NEXT_RADIX: radix_next = radix_reg + 2'd1;
            SW_ADD_SQUARE: inc = radix_square(radix_reg);
            SW_ADD_RADIX:  inc = {3'd0, radix_base(radix_reg)};
            SW_ADD_ONE:    inc = 7'd1;
            default:       inc = '0;
        endcase
        sum       = start_count + COUNT_W'(inc);
        count_upd = (sum >= COUNT_MODULUS) ? (sum - COUNT_MODULUS) : sum;
    end

    assign count_next = count_upd;

    // One digit step: divide by ten through the reciprocal, others by shift
    assign prod = 45'(work_reg) * 45'(DIV10_MULT);

    always_comb
    begin
        quot            = work_reg;
        quot_times_base = '0;
        case (radix_reg)
            RADIX_DEC:
            begin
                quot            = COUNT_W'(prod >> DIV10_SHIFT);
                quot_times_base = (quot << 3) + (quot << 1);
            end
            RADIX_OCT:
            begin
                quot            = work_reg >> 3;
                quot_times_base = quot << 3;
            end
            RADIX_QUA:
            begin
                quot            = work_reg >> 2;
                quot_times_base = quot << 2;
            end
            RADIX_BIN:
            begin
                quot            = work_reg >> 1;
                quot_times_base = quot << 1;
            end
            default:
            begin
                quot            = work_reg;
                quot_times_base = '0;
            end
        endcase
        rem_full  = work_reg - quot_times_base;
        rem       = rem_full[3:0];
        work_next = cmd.update ? count_upd : quot;
    end

    assign status.last_digit = (idx_reg == IDX_W'(SHOWN - 1));

    // Control-side state: count, radix, digit index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            radix_reg <= RADIX_DEC;
            idx_reg   <= '0;
        end
        else
        begin
            if (cmd.update)
            begin
                count_reg <= count_next;
                radix_reg <= radix_next;
                idx_reg   <= '0;
            end
            else if (cmd.step)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            key_reg    <= key_code;
            switch_reg <= switch_code;
        end
        if (cmd.update || cmd.step)
        begin
            work_reg <= work_next;
        end
        for (int j = 0; j < SHOWN_MAX; j++)
        begin
            if (cmd.update)
            begin
                dig_reg[j] <= 4'd0;
            end
            else if (cmd.step && (j < SHOWN) && (idx_reg == IDX_W'(j)))
            begin
                dig_reg[j] <= rem;
            end
        end
        if (cmd.emit)
        begin
            // decimal never shows its thousands digit
            thousands_reg <= (radix_reg == RADIX_DEC) ? 4'd0 : dig_reg[3];
            hundreds_reg  <= dig_reg[2];
            tens_reg      <= dig_reg[1];
            units_reg     <= dig_reg[0];
            radix_out_reg <= radix_reg;
        end
    end

    assign digit_thousands = thousands_reg;
    assign digit_hundreds  = hundreds_reg;
    assign digit_tens      = tens_reg;
    assign digit_units     = units_reg;
    assign radix_code      = radix_out_reg;

endmodule

>>> hdl/radix_select_push_counter_unit.sv
// Radix select push counter: counts button presses and shows them in a chosen radix.
//
// Input channel (in_valid/in_ready): each transfer carries key_code and
// switch_code. Key codes 114 and 115 clear the count first; switch 1 steps
// the radix (decimal, octal, base four, binary, then decimal again), switch
// 2 adds the base squared, switch 3 adds the base, switch 4 adds one.
// Output channel (out_valid/out_ready): one transfer per input, with the
// min(DIGITS,4) low digits of the count in the current radix and the radix code.
// The count wraps modulo 2,560,000; in decimal the thousands digit reads 0.
//
// Each item goes through an update state, a convert state that produces the
// shown digits (min(DIGITS,4)) one at a time, then an emit state that loads
// the output register, which raises out_valid. One item is in work at a
// time, so a new input is not taken until the previous item has been
// emitted; the digit loop through the shared divide step sets the pace.
// A new input is taken while a result waits in the output register; if
// out_ready stays low the next result waits in the datapath and the input
// side stalls. Reset clears the count, selects decimal and empties the
// output register.
module radix_select_push_counter_unit #(
    parameter int DIGITS = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] key_code,
    input  logic [7:0] switch_code,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [3:0] digit_thousands,
    output logic [3:0] digit_hundreds,
    output logic [3:0] digit_tens,
    output logic [3:0] digit_units,
    output logic [1:0] radix_code
);
    import rsp_pkg::*;

    rsp_cmd_t    cmd;
    rsp_status_t status;

    // Sequencer
    rsp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Count, radix and digit conversion
    rsp_datapath #(
        .DIGITS (DIGITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .key_code        (key_code),
        .switch_code     (switch_code),
        .cmd             (cmd),
        .status          (status),
        .digit_thousands (digit_thousands),
        .digit_hundreds  (digit_hundreds),
        .digit_tens      (digit_tens),
        .digit_units     (digit_units),
        .radix_code      (radix_code)
    );

endmodule
